// ===== sv/goldbach_prime_pair_finder_defines.svh =====
// ----------------------------------------------------------------------------
// Goldbach prime pair finder assertion macros
// Concurrent assertion wrappers clocked on clk and disabled while rst_n is low.
// ----------------------------------------------------------------------------
`ifndef GOLDBACH_PRIME_PAIR_FINDER_DEFINES_SVH
`define GOLDBACH_PRIME_PAIR_FINDER_DEFINES_SVH

`ifndef SYNTH
`define GPP_ASSERT(lbl, expr) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (expr)) \
        else $error("assertion failed");
`define GPP_IMPLY(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("assertion failed");
`define GPP_NEXT(lbl, ante, cons) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("assertion failed");
`else
`define GPP_ASSERT(lbl, expr)
`define GPP_IMPLY(lbl, ante, cons)
`define GPP_NEXT(lbl, ante, cons)
`endif

`endif

// ===== sv/gpp_pkg.sv =====
// ----------------------------------------------------------------------------
// Goldbach prime pair finder package
// Shared constants, status codes, state encoding and control structs.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

package gpp_pkg;

    localparam int NUMBER_BITS_DEF = 16;
    localparam int FIELD_W         = 16;
    localparam int IN_TDATA_W      = 16;
    localparam int OUT_TDATA_W     = 40;

    typedef enum logic [1:0] {
        ST_FOUND = 2'd0,
        ST_ODD   = 2'd1,
        ST_NONE  = 2'd2
    } status_t;

    typedef enum logic [3:0] {
        S_IDLE,
        S_CLASSIFY,
        S_P_CHECK,
        S_T_INIT,
        S_T_CMP,
        S_T_DIV,
        S_T_REM,
        S_P_NEXT,
        S_EMIT
    } state_t;

    typedef struct packed {
        logic    in_ready;
        logic    load_n;
        logic    init_test;
        logic    test_sel;
        logic    div_start;
        logic    div_step;
        logic    next_d;
        logic    next_p;
        logic    load_out;
        status_t out_kind;
    } cmd_t;

    typedef struct packed {
        logic n_odd;
        logic n_four;
        logic n_gt_four;
        logic p_lt_n;
        logic v_le_one;
        logic dsq_gt_v;
        logic div_last;
        logic rem_zero;
        logic out_free;
    } sts_t;

endpackage

`default_nettype wire

// ===== sv/gpp_ctrl.sv =====
// ----------------------------------------------------------------------------
// Goldbach prime pair finder controller
// Sequences classification, the candidate search and the trial divisions.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none

module gpp_ctrl (
    input  wire logic          clk,
    input  wire logic          rst_n,
    input  wire logic          in_valid,
    input  wire gpp_pkg::sts_t sts,
    output gpp_pkg::cmd_t      cmd
);
    import gpp_pkg::*;

    state_t  state_reg, state_next;
    logic    sel_reg, sel_next;
    status_t kind_reg, kind_next;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg <= S_IDLE;
            sel_reg   <= 1'b0;
            kind_reg  <= ST_NONE;
        end
        else
        begin
            state_reg <= state_next;
            sel_reg   <= sel_next;
            kind_reg  <= kind_next;
        end
    end

    always_comb
    begin
        state_next   = state_reg;
        sel_next     = sel_reg;
        kind_next    = kind_reg;
        cmd          = '0;
        cmd.out_kind = kind_reg;
        cmd.test_sel = sel_reg;
        case (state_reg)
            S_IDLE:
            begin
                cmd.in_ready = 1'b1;
                if (in_valid)
                begin
                    cmd.load_n = 1'b1;
                    state_next = S_CLASSIFY;
                end
            end
            S_CLASSIFY:
            begin
                if (sts.n_odd)
                begin
                    kind_next  = ST_ODD;
                    state_next = S_EMIT;
                end
                else if (sts.n_four)
                begin
                    kind_next  = ST_FOUND;
                    state_next = S_EMIT;
                end
                else if (sts.n_gt_four)
                begin
                    state_next = S_P_CHECK;
                end
                else
                begin
                    kind_next  = ST_NONE;
                    state_next = S_EMIT;
                end
            end
            S_P_CHECK:
            begin
                if (sts.p_lt_n)
                begin
                    sel_next   = 1'b0;
                    state_next = S_T_INIT;
                end
                else
                begin
                    kind_next  = ST_NONE;
                    state_next = S_EMIT;
                end
            end
            S_T_INIT:
            begin
                cmd.init_test = 1'b1;
                state_next    = S_T_CMP;
            end
            S_T_CMP:
            begin
                if (sts.v_le_one)
                begin
                    state_next = S_P_NEXT;
                end
                else if (sts.dsq_gt_v)
                begin
                    // The value under test is prime.
                    if (sel_reg)
                    begin
                        kind_next  = ST_FOUND;
                        state_next = S_EMIT;
                    end
                    else
                    begin
                        sel_next   = 1'b1;
                        state_next = S_T_INIT;
                    end
                end
                else
                begin
                    cmd.div_start = 1'b1;
                    state_next    = S_T_DIV;
                end
            end
            S_T_DIV:
            begin
                cmd.div_step = 1'b1;
                if (sts.div_last)
                begin
                    state_next = S_T_REM;
                end
            end
            S_T_REM:
            begin
                if (sts.rem_zero)
                begin
                    state_next = S_P_NEXT;
                end
                else
                begin
                    cmd.next_d = 1'b1;
                    state_next = S_T_CMP;
                end
            end
            S_P_NEXT:
            begin
                cmd.next_p = 1'b1;
                state_next = S_P_CHECK;
            end
            S_EMIT:
            begin
                if (sts.out_free)
                begin
                    cmd.load_out = 1'b1;
                    state_next   = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

endmodule

`default_nettype wire

// ===== sv/gpp_datapath.sv =====
// ----------------------------------------------------------------------------
// Goldbach prime pair finder datapath
// Holds n and the candidate, runs a bit-serial remainder unit and the result.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps
`default_nettype none
`include "goldbach_prime_pair_finder_defines.svh"

module gpp_datapath #(
    parameter int NUMBER_BITS = gpp_pkg::NUMBER_BITS_DEF
) (
    input  wire logic                           clk,
    input  wire logic                           rst_n,
    input  wire gpp_pkg::cmd_t                  cmd,
    input  wire logic [gpp_pkg::IN_TDATA_W-1:0] number,
    input  wire logic                           out_ready,
    output gpp_pkg::sts_t                       sts,
    output logic                                out_valid,
    output logic [gpp_pkg::FIELD_W-1:0]         larger_part,
    output logic [gpp_pkg::FIELD_W-1:0]         smaller_prime,
    output gpp_pkg::status_t                    status
);
    import gpp_pkg::*;

    localparam int W     = NUMBER_BITS;
    localparam int CNT_W = $clog2(NUMBER_BITS);

    logic [W-1:0]     n_reg, n_next;
    logic [W-1:0]     p_reg, p_next;
    logic [W-1:0]     v_reg, v_next;
    logic [W-1:0]     d_reg, d_next;
    logic [W:0]       dsq_reg, dsq_next;
    logic [W-1:0]     a_reg, a_next;
    logic [W:0]       rem_reg, rem_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;
    logic             out_valid_reg, out_valid_next;
    logic [FIELD_W-1:0] larger_reg, larger_next;
    logic [FIELD_W-1:0] smaller_reg, smaller_next;
    status_t          status_reg, status_next;

    logic [W-1:0] n_in;
    logic [W:0]   rem_sh;
    logic [W:0]   d_ext;
    logic         rem_ge;

    assign n_in   = W'(number);
    assign d_ext  = {1'b0, d_reg};
    assign rem_sh = {rem_reg[W-1:0], a_reg[W-1]};
    assign rem_ge = (rem_sh >= d_ext);

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            out_valid_reg <= 1'b0;
        end
        else
        begin
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        n_reg       <= n_next;
        p_reg       <= p_next;
        v_reg       <= v_next;
        d_reg       <= d_next;
        dsq_reg     <= dsq_next;
        a_reg       <= a_next;
        rem_reg     <= rem_next;
        cnt_reg     <= cnt_next;
        larger_reg  <= larger_next;
        smaller_reg <= smaller_next;
        status_reg  <= status_next;
    end

    always_comb
    begin
        n_next         = n_reg;
        p_next         = p_reg;
        v_next         = v_reg;
        d_next         = d_reg;
        dsq_next       = dsq_reg;
        a_next         = a_reg;
        rem_next       = rem_reg;
        cnt_next       = cnt_reg;
        larger_next    = larger_reg;
        smaller_next   = smaller_reg;
        status_next    = status_reg;
        out_valid_next = out_valid_reg && !out_ready;

        if (cmd.load_n)
        begin
            n_next = n_in;
            // Four is answered as two plus two; every other search starts at three.
            p_next = (n_in == W'(4)) ? W'(2) : W'(3);
        end
        if (cmd.next_p)
        begin
            p_next = p_reg + W'(2);
        end
        if (cmd.init_test)
        begin
            v_next   = cmd.test_sel ? (n_reg - p_reg) : p_reg;
            d_next   = W'(2);
            dsq_next = (W + 1)'(4);
        end
        if (cmd.next_d)
        begin
            // (d + 1)^2 = d^2 + 2d + 1
            d_next   = d_reg + W'(1);
            dsq_next = dsq_reg + {d_reg, 1'b1};
        end
        if (cmd.div_start)
        begin
            a_next   = v_reg;
            rem_next = '0;
            cnt_next = '0;
        end
        if (cmd.div_step)
        begin
            rem_next = rem_ge ? (rem_sh - d_ext) : rem_sh;
            a_next   = {a_reg[W-2:0], 1'b0};
            cnt_next = cnt_reg + CNT_W'(1);
        end
        if (cmd.load_out)
        begin
            out_valid_next = 1'b1;
            status_next    = cmd.out_kind;
            if (cmd.out_kind == ST_FOUND)
            begin
                larger_next  = FIELD_W'(n_reg - p_reg);
                smaller_next = FIELD_W'(p_reg);
            end
            else
            begin
                larger_next  = '0;
                smaller_next = '0;
            end
        end
    end

    always_comb
    begin
        sts.n_odd     = n_reg[0];
        sts.n_four    = (n_reg == W'(4));
        sts.n_gt_four = (n_reg > W'(4));
        sts.p_lt_n    = (p_reg < n_reg);
        sts.v_le_one  = (v_reg <= W'(1));
        sts.dsq_gt_v  = (dsq_reg > {1'b0, v_reg});
        sts.div_last  = (cnt_reg == CNT_W'(W - 1));
        sts.rem_zero  = (rem_reg == '0);
        sts.out_free  = !out_valid_reg || out_ready;
    end

    assign out_valid     = out_valid_reg;
    assign larger_part   = larger_reg;
    assign smaller_prime = smaller_reg;
    assign status        = status_reg;

    `GPP_IMPLY(a_load_when_free, cmd.load_out, !out_valid_reg || out_ready)
    `GPP_IMPLY(a_zero_unless_found, out_valid_reg && (status_reg != ST_FOUND),
               (larger_reg == '0) && (smaller_reg == '0))
    `GPP_NEXT(a_rem_below_divisor, cmd.div_step, rem_reg < d_ext)

endmodule

`default_nettype wire

// ===== sv/goldbach_prime_pair_finder.sv =====
// ----------------------------------------------------------------------------
// Goldbach prime pair finder
// Splits an even number into two primes by search and trial division.
// ----------------------------------------------------------------------------
// One request on the input stream carries n; one request on the output stream
// returns n - p, the smallest prime p for which n - p is prime, and a status
// (found, odd input, no pair). Only one number is worked on at a time. Each
// trial division runs through a bit-serial remainder unit, after a divisor
// square compare and before a remainder check, so the work per item depends
// on n. A finished result waits in an output register while the next number
// is already accepted.
`timescale 1ns / 1ps
`default_nettype none

module goldbach_prime_pair_finder #(
    parameter int NUMBER_BITS = gpp_pkg::NUMBER_BITS_DEF
) (
    input  wire logic                            clk,
    input  wire logic                            rst_n,
    input  wire logic                            s_tvalid,
    output logic                                 s_tready,
    // [15:0] number
    input  wire logic [gpp_pkg::IN_TDATA_W-1:0]  s_tdata,
    output logic                                 m_tvalid,
    input  wire logic                            m_tready,
    // [15:0] larger_part, [31:16] smaller_prime, [33:32] status, [39:34] zero
    output logic [gpp_pkg::OUT_TDATA_W-1:0]      m_tdata
);
    import gpp_pkg::*;

    cmd_t               cmd;
    sts_t               sts;
    logic [FIELD_W-1:0] larger_part;
    logic [FIELD_W-1:0] smaller_prime;
    status_t            status;

    gpp_ctrl u_ctrl (
        .clk      (clk),
        .rst_n    (rst_n),
        .in_valid (s_tvalid),
        .sts      (sts),
        .cmd      (cmd)
    );

    gpp_datapath #(
        .NUMBER_BITS (NUMBER_BITS)
    ) u_datapath (
        .clk           (clk),
        .rst_n         (rst_n),
        .cmd           (cmd),
        .number        (s_tdata),
        .out_ready     (m_tready),
        .sts           (sts),
        .out_valid     (m_tvalid),
        .larger_part   (larger_part),
        .smaller_prime (smaller_prime),
        .status        (status)
    );

    assign s_tready = cmd.in_ready;
    assign m_tdata  = {(OUT_TDATA_W - 2 * FIELD_W - 2)'(0), status, smaller_prime,
                       larger_part};

endmodule

`default_nettype wire

// ===== bench/tb.sv =====
// ----------------------------------------------------------------------------
// Goldbach prime pair finder testbench
// Streams even, odd and edge-case numbers through the finder and checks every
// returned pair and status against a trial-division predictor, under several
// idling patterns and one long back-pressure stretch.
// ----------------------------------------------------------------------------
`timescale 1ns / 1ps

module tb;
    import gpp_pkg::*;

    // CYCLE_LIMIT leaves a wide margin over the whole run.
    localparam longint unsigned CYCLE_LIMIT  = 64'd20_000_000;
    localparam int              DRAIN_CYCLES = 200;
    localparam int              HOLD_CYCLES  = 4000;

    typedef struct packed {
        logic [FIELD_W-1:0] larger_part;
        logic [FIELD_W-1:0] smaller_prime;
        status_t            status;
    } goldbach_pair_t;

    logic                   clk      = 1'b0;
    logic                   rst_n    = 1'b0;
    logic                   s_tvalid = 1'b0;
    logic                   s_tready;
    logic [IN_TDATA_W-1:0]  s_tdata  = '0;
    logic                   m_tvalid;
    logic                   m_tready = 1'b0;
    logic [OUT_TDATA_W-1:0] m_tdata;

    goldbach_prime_pair_finder i_dut (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata)
    );

    goldbach_pair_t  pair_q[$];
    int              error_count    = 0;
    int              numbers_sent   = 0;
    int              pairs_checked  = 0;
    int              send_idle_pct  = 0;
    int              recv_stall_pct = 0;
    int              recv_hold_left = 0;
    longint unsigned cycle_count    = 0;

    always #2 clk = ~clk;

    // ------------------------------------------------------------------
    // Predictor
    // ------------------------------------------------------------------
    function automatic bit prime_by_trial(input int unsigned v);
        int unsigned d;
        if (v <= 1)
            return 1'b0;
        for (d = 2; d * d <= v; d++)
        begin
            if (v % d == 0)
                return 1'b0;
        end
        return 1'b1;
    endfunction

    function automatic goldbach_pair_t split_number(input logic [IN_TDATA_W-1:0] number);
        goldbach_pair_t pair;
        int unsigned    n;
        int unsigned    p;
        n    = 32'(number);
        pair = '{larger_part: '0, smaller_prime: '0, status: ST_NONE};
        if (n[0])
        begin
            pair.status = ST_ODD;
        end
        else if (n == 4)
        begin
            pair = '{larger_part: 16'd2, smaller_prime: 16'd2, status: ST_FOUND};
        end
        else if (n > 4)
        begin
            for (p = 3; p < n; p += 2)
            begin
                if (prime_by_trial(p) && prime_by_trial(n - p))
                begin
                    pair.larger_part   = FIELD_W'(n - p);
                    pair.smaller_prime = FIELD_W'(p);
                    pair.status        = ST_FOUND;
                    break;
                end
            end
        end
        return pair;
    endfunction

    // ------------------------------------------------------------------
    // Request driver: called at a falling edge, returns at a falling edge
    // with tvalid still high so back-to-back requests need no gap.
    // ------------------------------------------------------------------
    task automatic send_number(input logic [IN_TDATA_W-1:0] number);
        if ($urandom_range(99, 0) < send_idle_pct)
        begin
            s_tvalid = 1'b0;
            @(negedge clk);
            while ($urandom_range(99, 0) < send_idle_pct)
                @(negedge clk);
        end
        s_tvalid = 1'b1;
        s_tdata  = number;
        @(posedge clk);
        while (!s_tready)
            @(posedge clk);
        pair_q.push_back(split_number(number));
        numbers_sent++;
        @(negedge clk);
    endtask

    function automatic logic [IN_TDATA_W-1:0] pick_number();
        int unsigned sel;
        sel = $urandom_range(99, 0);
        if (sel < 70)
            return IN_TDATA_W'($urandom_range(65535, 0)) & 16'hFFFE;
        else if (sel < 85)
            return IN_TDATA_W'($urandom_range(65535, 0)) | 16'h0001;
        else
            return IN_TDATA_W'($urandom_range(200, 0)) & 16'hFFFE;
    endfunction

    task automatic send_random_batch(input int count);
        repeat (count)
            send_number(pick_number());
    endtask

    task automatic wait_drain();
        s_tvalid = 1'b0;
        while (pair_q.size() != 0)
            @(negedge clk);
        repeat (DRAIN_CYCLES) @(negedge clk);
    endtask

    // ------------------------------------------------------------------
    // Receiver: random stalls, plus a long hold-off when one is requested.
    // ------------------------------------------------------------------
    always @(negedge clk)
    begin
        if (recv_hold_left > 0)
        begin
            m_tready       <= 1'b0;
            recv_hold_left <= recv_hold_left - 1;
        end
        else
        begin
            m_tready <= ($urandom_range(99, 0) >= recv_stall_pct);
        end
    end

    // ------------------------------------------------------------------
    // Result checker
    // ------------------------------------------------------------------
    always @(posedge clk)
    begin
        goldbach_pair_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pair_q.size() == 0)
            begin
                $error("result with no request pending: tdata %h", m_tdata);
                error_count++;
            end
            else
            begin
                want = pair_q.pop_front();
                pairs_checked++;
                if (m_tdata[15:0] !== want.larger_part)
                begin
                    $error("larger_part expected %0d actual %0d",
                           want.larger_part, m_tdata[15:0]);
                    error_count++;
                end
                if (m_tdata[31:16] !== want.smaller_prime)
                begin
                    $error("smaller_prime expected %0d actual %0d",
                           want.smaller_prime, m_tdata[31:16]);
                    error_count++;
                end
                if (m_tdata[33:32] !== want.status)
                begin
                    $error("status expected %0d actual %0d",
                           want.status, m_tdata[33:32]);
                    error_count++;
                end
                if (m_tdata[39:34] !== '0)
                begin
                    $error("pad expected 0 actual %0d", m_tdata[39:34]);
                    error_count++;
                end
            end
        end
    end

    always @(posedge clk)
    begin
        cycle_count <= cycle_count + 1;
        if (cycle_count >= CYCLE_LIMIT)
        begin
            $display("tb: timeout after %0d cycles", cycle_count);
            $display("tb: done, errors");
            $finish;
        end
    end

    // ------------------------------------------------------------------
    // Tests
    // ------------------------------------------------------------------
    task automatic test_directed();
        logic [IN_TDATA_W-1:0] numbers[$];
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        // Zero and two have no pair, four is the two-plus-two case, the odd
        // values are rejected, and the rest are small, large or slow searches.
        numbers = '{16'd0, 16'd2, 16'd4, 16'd6, 16'd8, 16'd1, 16'd3, 16'd65535,
                    16'd65534, 16'd65532, 16'd63274, 16'd54244, 16'd43532,
                    16'd98, 16'd992, 16'd12, 16'd30, 16'h8000, 16'hAAAA,
                    16'h5554, 16'd5372, 16'd7426, 16'd2642, 16'h7FFF};
        foreach (numbers[i])
            send_number(numbers[i]);
        wait_drain();
    endtask

    task automatic test_no_idle();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        send_random_batch(16);
        wait_drain();
    endtask

    task automatic test_sender_idle();
        send_idle_pct  = 84;
        recv_stall_pct = 0;
        send_random_batch(16);
        wait_drain();
    endtask

    task automatic test_receiver_stall();
        send_idle_pct  = 0;
        recv_stall_pct = 84;
        send_random_batch(16);
        wait_drain();
    endtask

    task automatic test_both_idle();
        send_idle_pct  = 6;
        recv_stall_pct = 6;
        send_random_batch(16);
        wait_drain();
    endtask

    // Small numbers finish fast, so the output register and the core fill
    // up while the receiver holds off and the input has to stall.
    task automatic test_backpressure();
        send_idle_pct  = 0;
        recv_stall_pct = 0;
        recv_hold_left = HOLD_CYCLES;
        repeat (10)
            send_number(IN_TDATA_W'($urandom_range(60, 0)));
        wait_drain();
    endtask

    initial
    begin
        repeat (7) @(posedge clk);
        @(negedge clk);
        rst_n = 1'b1;
        @(negedge clk);

        test_directed();
        test_no_idle();
        test_sender_idle();
        test_receiver_stall();
        test_both_idle();
        test_backpressure();

        $display("tb: %0d numbers sent and %0d results checked", numbers_sent,
                 pairs_checked);
        $display("tb: covered edge values, odd inputs, idling mixes, long hold-off");
        if (error_count == 0)
            $display("tb: done, clean");
        else
            $display("tb: done, errors");
        $finish;
    end

endmodule

// ===== goldbach_prime_pair_finder.f =====
+incdir+sv
sv/gpp_pkg.sv
sv/gpp_ctrl.sv
sv/gpp_datapath.sv
sv/goldbach_prime_pair_finder.sv
bench/tb.sv
